### hdl/wsfr_pkg.sv
package wsfr_pkg;

    localparam logic [6:0] LEN_CODE_64 = 7'h7F;
    localparam logic [6:0] LEN_CODE_16 = 7'h7E;

    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_0  = 4'd0;
    localparam logic [3:0] BASE_HDR     = 4'd2;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EMPTY_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       is_control;
        logic       final_fragment;
        logic       end_of_frame;
        logic       status;
    } t_result;

    function automatic logic opcode_is_control(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    function automatic logic [3:0] ext_bytes(input logic [6:0] len_code);
        logic [3:0] n;
        if (len_code == LEN_CODE_64) begin
            n = EXT_BYTES_64;
        end else if (len_code == LEN_CODE_16) begin
            n = EXT_BYTES_16;
        end else begin
            n = EXT_BYTES_0;
        end
        return n;
    endfunction

endpackage

### hdl/wsfr_if.sv
interface wsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_data;
    logic [3:0] frame_opcode;
    logic       is_control;
    logic       final_fragment;
    logic       end_of_frame;
    logic       status;

    modport source (
        output valid, output payload_byte, output has_data, output frame_opcode,
        output is_control, output final_fragment, output end_of_frame, output status,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input has_data, input frame_opcode,
        input is_control, input final_fragment, input end_of_frame, input status,
        output ready
    );
endinterface

### hdl/websocket_frame_receiver.sv
// Channel  Dir  Port   Fields
// rx       in   i_rx   rx_byte[7:0]
// res      out  o_res  payload_byte, has_data, frame_opcode, is_control,
//                      final_fragment, end_of_frame, status
//
// One word per cycle sustained unless a stalled result holds it back; a word goes from the
// input register through wsfr_parse into the output register, from which the sink takes it.
// The rate is set by the header/payload state update in wsfr_parse, done combinationally per word.
// Reset is synchronous, active low; the receiver then expects header byte 0.
// A stalled result holds in the output register; one word waits in the input register.
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    wsfr_in_if.sink      i_rx,
    wsfr_out_if.source   o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       proc_fire;
    logic       res_valid;
    t_result    res;

    wsfr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc_fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign proc_fire  = r_in_valid && (!res_valid || !r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.has_data       = r_out.has_data;
    assign o_res.frame_opcode   = r_out.frame_opcode;
    assign o_res.is_control     = r_out.is_control;
    assign o_res.final_fragment = r_out.final_fragment;
    assign o_res.end_of_frame   = r_out.end_of_frame;
    assign o_res.status         = r_out.status;

`ifndef ASSERT_OFF
    a_empty_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.has_data |-> o_res.end_of_frame)
        else $error("empty result without end of frame");

    a_err_on_data_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status |-> !o_res.has_data && !o_res.is_control)
        else $error("error status on data or control result");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.has_data |-> o_res.status == STATUS_OK)
        else $error("payload result with error status");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc_fire |=> r_in_valid && $stable(r_in_byte))
        else $error("pending word lost");
`endif

endmodule

### hdl/wsfr_parse.sv
module wsfr_parse
    import wsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic        r_in_payload, n_in_payload;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_masked, n_masked;
    logic [6:0]  r_short_len, n_short_len;
    logic [63:0] r_ext_len, n_ext_len;
    logic [31:0] r_key, n_key;
    logic [63:0] r_remaining, n_remaining;
    logic [1:0]  r_key_idx, n_key_idx;

    logic [3:0]  idx;
    logic [3:0]  cur_ext;
    logic [3:0]  new_ext;
    logic [3:0]  need;
    logic [1:0]  key_pos;
    logic [63:0] len;
    logic [7:0]  key_byte;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_opcode     = r_opcode;
        n_fin        = r_fin;
        n_masked     = r_masked;
        n_short_len  = r_short_len;
        n_ext_len    = r_ext_len;
        n_key        = r_key;
        n_remaining  = r_remaining;
        n_key_idx    = r_key_idx;

        o_res_valid         = 1'b0;
        o_res.payload_byte  = 8'd0;
        o_res.has_data      = 1'b0;
        o_res.frame_opcode  = r_opcode;
        o_res.is_control    = opcode_is_control(r_opcode);
        o_res.final_fragment = r_fin;
        o_res.end_of_frame  = 1'b0;
        o_res.status        = STATUS_OK;

        idx      = r_hdr_cnt - 4'd2;
        cur_ext  = ext_bytes(r_short_len);
        key_pos  = 2'(idx - cur_ext);
        key_byte = r_masked ? r_key[{r_key_idx, 3'b000} +: 8] : 8'd0;
        new_ext  = 4'd0;
        need     = 4'd0;
        len      = 64'd0;

        if (r_in_payload) begin
            o_res_valid        = 1'b1;
            o_res.payload_byte = i_byte ^ key_byte;
            o_res.has_data     = 1'b1;
            o_res.end_of_frame = (r_remaining == 64'd1);
            n_key_idx          = r_key_idx + 2'd1;
            n_remaining        = r_remaining - 64'd1;
            if (r_remaining == 64'd1) begin
                n_in_payload = 1'b0;
            end
        end else if (r_hdr_cnt == 4'd0) begin
            n_fin     = i_byte[7];
            n_opcode  = i_byte[3:0];
            n_hdr_cnt = 4'd1;
        end else begin
            if (r_hdr_cnt == 4'd1) begin
                n_masked    = i_byte[7];
                n_short_len = i_byte[6:0];
                n_ext_len   = 64'd0;
                n_key       = 32'd0;
            end else if (idx < cur_ext) begin
                n_ext_len = {r_ext_len[55:0], i_byte};
            end else begin
                n_key[{key_pos, 3'b000} +: 8] = r_key[{key_pos, 3'b000} +: 8] | i_byte;
            end
            n_hdr_cnt = r_hdr_cnt + 4'd1;
            new_ext   = ext_bytes(n_short_len);
            need      = BASE_HDR + new_ext + (n_masked ? KEY_BYTES : 4'd0);
            len       = (new_ext != 4'd0) ? n_ext_len : {57'd0, n_short_len};
            if (n_hdr_cnt == need) begin
                n_hdr_cnt = 4'd0;
                n_key_idx = 2'd0;
                if (len == 64'd0) begin
                    o_res_valid        = 1'b1;
                    o_res.end_of_frame = 1'b1;
                    o_res.status       = opcode_is_control(r_opcode) ? STATUS_OK
                                                                     : STATUS_EMPTY_ERR;
                end else begin
                    n_remaining  = len;
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= 4'd0;
            r_key_idx    <= 2'd0;
        end else if (i_fire) begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_key_idx    <= n_key_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_opcode    <= n_opcode;
            r_fin       <= n_fin;
            r_masked    <= n_masked;
            r_short_len <= n_short_len;
            r_ext_len   <= n_ext_len;
            r_key       <= n_key;
            r_remaining <= n_remaining;
        end
    end

endmodule

### dv/websocket_frame_receiver_tb.sv
`timescale 1ns / 100ps

module websocket_frame_receiver_tb
    import wsfr_pkg::*;
();

    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_TEXT     = 4'h1;
    localparam logic [3:0] OP_RESERVED = 4'hF;
    localparam int RANDOM_WORDS  = 1100;
    localparam int HUGE_PAYLOAD  = 40;
    localparam int STALL_AT      = 300;
    localparam int STALL_CYCLES  = 80;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 1000;

    typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_frame_len;

    class t_deframe_scoreboard;
        t_result expected_q[$];
        int errors = 0;
        logic        in_payload = 1'b0;
        logic [3:0]  hdr_count = '0;
        logic [3:0]  opcode = '0;
        logic        fin = 1'b0;
        logic        masked = 1'b0;
        logic [6:0]  len_code = '0;
        logic [63:0] ext_len = '0;
        logic [31:0] key = '0;
        logic [63:0] remaining = '0;
        logic [1:0]  key_idx = '0;

        function logic [3:0] length_bytes();
            case (len_code)
                LEN_CODE_64: return EXT_BYTES_64;
                LEN_CODE_16: return EXT_BYTES_16;
                default:     return EXT_BYTES_0;
            endcase
        endfunction

        function void push_result(logic [7:0] data, logic has, logic eof, logic st);
            t_result r;
            r.payload_byte   = data;
            r.has_data       = has;
            r.frame_opcode   = opcode;
            r.is_control     = opcode inside {OP_CLOSE, OP_PING, OP_PONG};
            r.final_fragment = fin;
            r.end_of_frame   = eof;
            r.status         = st;
            expected_q.push_back(r);
        endfunction

        function void note_word(logic [7:0] b);
            logic [7:0]  data;
            logic [3:0]  ext;
            logic [3:0]  idx;
            logic [3:0]  need;
            logic [1:0]  kb;
            logic [63:0] len;
            if (in_payload) begin
                data = masked ? b ^ key[8*key_idx +: 8] : b;
                key_idx = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                if (remaining == 0) begin
                    in_payload = 1'b0;
                end
                push_result(data, 1'b1, remaining == 0, STATUS_OK);
                return;
            end
            if (hdr_count == 0) begin
                fin = b[7];
                opcode = b[3:0];
                hdr_count = 4'd1;
                return;
            end
            if (hdr_count == 1) begin
                masked = b[7];
                len_code = b[6:0];
                ext_len = '0;
                key = '0;
            end else begin
                idx = hdr_count - BASE_HDR;
                ext = length_bytes();
                if (idx < ext) begin
                    ext_len = {ext_len[55:0], b};
                end else begin
                    kb = 2'(idx - ext);
                    key[8*kb +: 8] = b;
                end
            end
            hdr_count = hdr_count + 4'd1;
            ext = length_bytes();
            need = BASE_HDR + ext + (masked ? KEY_BYTES : 4'd0);
            if (hdr_count != need) begin
                return;
            end
            hdr_count = '0;
            key_idx = '0;
            len = (ext != 0) ? ext_len : {57'd0, len_code};
            if (len == 0) begin
                push_result(8'd0, 1'b0, 1'b1,
                            (opcode inside {OP_CLOSE, OP_PING, OP_PONG}) ?
                            STATUS_OK : STATUS_EMPTY_ERR);
            end else begin
                remaining = len;
                in_payload = 1'b1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("has_data", want.has_data, got.has_data);
            compare_field("frame_opcode", want.frame_opcode, got.frame_opcode);
            compare_field("is_control", want.is_control, got.is_control);
            compare_field("final_fragment", want.final_fragment, got.final_fragment);
            compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   sent_words = 0;
    int   idle_cycles = 0;
    t_deframe_scoreboard sb = new();

    wsfr_in_if  rx_if();
    wsfr_out_if res_if();

    websocket_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n === 1'b1) begin
            if (res_if.valid && res_if.ready) begin
                got.payload_byte   = res_if.payload_byte;
                got.has_data       = res_if.has_data;
                got.frame_opcode   = res_if.frame_opcode;
                got.is_control     = res_if.is_control;
                got.final_fragment = res_if.final_fragment;
                got.end_of_frame   = res_if.end_of_frame;
                got.status         = res_if.status;
                sb.check_result(got);
            end
            if (rx_if.valid && rx_if.ready) begin
                sb.note_word(rx_if.rx_byte);
            end
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        int hold;
        int taken;
        taken = 0;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (taken == STALL_AT) begin
                hold = STALL_CYCLES;
            end else if ((taken / 100) % 4 == 1) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 5);
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            taken++;
        end
    end

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = ((sent_words / 128) % 4 == 3) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sent_words++;
    endtask

    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input t_frame_len form,
                              input logic [63:0] len, input logic [31:0] key,
                              input int n_payload);
        send_word({fin, rsv, op});
        case (form)
            LEN_SHORT: begin
                send_word({masked, len[6:0]});
            end
            LEN_EXT16: begin
                send_word({masked, LEN_CODE_16});
                send_word(len[15:8]);
                send_word(len[7:0]);
            end
            default: begin
                send_word({masked, LEN_CODE_64});
                for (int i = 7; i >= 0; i--) begin
                    send_word(len[8*i +: 8]);
                end
            end
        endcase
        if (masked) begin
            for (int i = 0; i < 4; i++) begin
                send_word(key[8*i +: 8]);
            end
        end
        repeat (n_payload) send_word(8'($urandom));
    endtask

    task automatic send_random_frame();
        int pick;
        int len;
        t_frame_len form;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            form = LEN_SHORT;
            len = $urandom_range(0, 12);
        end else if (pick < 68) begin
            form = LEN_SHORT;
            len = $urandom_range(0, 125);
        end else if (pick < 82) begin
            form = LEN_EXT16;
            len = $urandom_range(0, 20);
        end else if (pick < 86) begin
            form = LEN_EXT16;
            len = 256 + $urandom_range(0, 60);
        end else begin
            form = LEN_EXT64;
            len = $urandom_range(0, 20);
        end
        send_frame(1'($urandom), 3'($urandom), 4'($urandom), $urandom_range(0, 3) != 0,
                   form, 64'(len), $urandom, len);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty text frame, empty masked ping, masked reserved opcode,
        // pong with 16-bit length, empty continuation with 16-bit length
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0);
        send_frame(1'b1, 3'b000, OP_PING, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
        send_frame(1'b0, 3'b111, OP_RESERVED, 1'b1, LEN_SHORT, 64'd3, 32'hA5C3_0F81, 3);
        send_frame(1'b1, 3'b000, OP_PONG, 1'b0, LEN_EXT16, 64'd1, 32'd0, 1);
        send_frame(1'b0, 3'b000, OP_CONT, 1'b0, LEN_EXT16, 64'd0, 32'd0, 0);

        while (sent_words < RANDOM_WORDS) begin
            send_random_frame();
        end

        // length with the top bit set: stays in payload for the rest of the run
        send_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, LEN_EXT64,
                   {1'b1, 63'($urandom)}, $urandom, HUGE_PAYLOAD);
        rx_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (sb.expected_q.size() != 0) begin
                $error("%0d expected result words never arrived", sb.expected_q.size());
            end
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
